/* design/lzss_descramble_decompressor_defines.svh */
// ----------------------------------------------------------------------------
// lzss_descramble_decompressor_defines
// Assertion macros for the LZSS descramble decompressor.
// ----------------------------------------------------------------------------
`ifndef LZSS_DESCRAMBLE_DECOMPRESSOR_DEFINES_SVH
`define LZSS_DESCRAMBLE_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZSSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LZSSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lzssd_pkg.sv */
// ----------------------------------------------------------------------------
// lzssd_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lzssd_pkg;

    localparam int WIN_BITS = 12;
    localparam logic [WIN_BITS:0]   WIN_DEPTH  = (WIN_BITS + 1)'(1 << WIN_BITS);
    localparam logic [WIN_BITS-1:0] WIN_START  = WIN_BITS'(12'hFEE);
    localparam logic [7:0]          KEY_RESET  = 8'hFF;
    localparam logic [3:0]          FLAG_COUNT = 4'd8;
    // Match length minus one equals the low nibble plus this bias.
    localparam logic [4:0]          MATCH_BIAS = 5'd2;

    // Decode phase codes; the unused code behaves like PH_FLAG.
    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_BYTE = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NONE  = 2'd0;
    localparam kind_t KIND_LIT   = 2'd1;
    localparam kind_t KIND_MATCH = 2'd2;

    typedef struct packed {
        logic accept;
        logic lit_emit;
        logic rd_issue;
        logic match_emit;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  out_free;
        logic  match_end;
    } dp_stat_t;

endpackage

/* design/lzssd_ctrl.sv */
// ----------------------------------------------------------------------------
// lzssd_ctrl
// Sequencer: accepts items, steps literal output and match copy.
// ----------------------------------------------------------------------------
module lzssd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lzssd_pkg::dp_stat_t  stat,
    output lzssd_pkg::ctrl_cmd_t cmd
);
    import lzssd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LIT  = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_stall       = (state_reg != ST_IDLE);
    assign cmd.accept     = (state_reg == ST_IDLE) && in_valid;
    assign cmd.lit_emit   = (state_reg == ST_LIT) && stat.out_free;
    assign cmd.rd_issue   = (state_reg == ST_READ);
    assign cmd.match_emit = (state_reg == ST_EMIT) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && stat.kind == KIND_LIT)
                    state_next = ST_LIT;
                else if (in_valid && stat.kind == KIND_MATCH)
                    state_next = ST_READ;
            end
            ST_LIT:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                    state_next = stat.match_end ? ST_IDLE : ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* design/lzssd_dp.sv */
// ----------------------------------------------------------------------------
// lzssd_dp
// Descramble, decode state, history window and output register.
// ----------------------------------------------------------------------------
module lzssd_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_stream,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [7:0]           out_byte,
    output logic                 run_last,
    input  lzssd_pkg::ctrl_cmd_t cmd,
    output lzssd_pkg::dp_stat_t  stat
);
    import lzssd_pkg::*;

    logic [7:0]          win_mem [WIN_DEPTH];

    logic [7:0]          key_reg;
    logic [7:0]          pos_reg,      pos_next;
    logic [1:0]          phase_reg,    phase_next;
    logic [7:0]          flag_reg,     flag_next;
    logic [3:0]          left_reg,     left_next;
    logic [7:0]          low_reg,      low_next;
    logic [WIN_BITS-1:0] wp_reg,       wp_next;
    logic [WIN_BITS:0]   fill_reg,     fill_next;
    logic                pend_last_reg, pend_last_next;
    logic                out_valid_reg, out_valid_next;

    logic [7:0]          lit_reg,      lit_next;
    logic [WIN_BITS-1:0] src_reg,      src_next;
    logic [4:0]          len_m1_reg,   len_m1_next;
    logic [4:0]          idx_reg,      idx_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [7:0]          rdata_reg;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                run_last_reg, run_last_next;

    logic [7:0]          scr;
    logic [WIN_BITS-1:0] rd_addr;
    logic [WIN_BITS-1:0] rd_rel;
    logic                rd_hit;
    logic                emit;
    logic                finish;
    logic                clear;
    logic [3:0]          left_dec;
    logic [7:0]          emit_data;
    kind_t               dec_kind;

    assign scr     = in_byte ^ (key_reg & pos_reg);
    assign rd_addr = src_reg + {{(WIN_BITS-5){1'b0}}, idx_reg};
    // Window fills in order from the start pointer; unwritten entries read zero.
    assign rd_rel  = rd_addr - WIN_START;
    assign rd_hit  = ({1'b0, rd_rel} < fill_reg);

    always_comb
    begin
        case (phase_reg)
            PH_BYTE: dec_kind = flag_reg[0] ? KIND_LIT : KIND_NONE;
            PH_HIGH: dec_kind = KIND_MATCH;
            default: dec_kind = KIND_NONE;
        endcase
    end

    assign stat.kind      = dec_kind;
    assign stat.out_free  = !out_valid_reg || !out_stall;
    assign stat.match_end = (idx_reg == len_m1_reg);

    assign emit      = cmd.lit_emit || cmd.match_emit;
    assign finish    = cmd.lit_emit || (cmd.match_emit && stat.match_end);
    assign clear     = (cmd.accept && end_of_stream && stat.kind == KIND_NONE)
                     || (finish && pend_last_reg);
    assign left_dec  = left_reg - 4'd1;
    assign emit_data = cmd.lit_emit ? lit_reg : (rd_valid_reg ? rdata_reg : 8'h00);

    always_comb
    begin
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        flag_next      = flag_reg;
        left_next      = left_reg;
        low_next       = low_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        pend_last_next = pend_last_reg;
        lit_next       = lit_reg;
        src_next       = src_reg;
        len_m1_next    = len_m1_reg;
        idx_next       = idx_reg;
        rd_valid_next  = rd_valid_reg;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.accept)
        begin
            pos_next       = pos_reg + 8'd1;
            pend_last_next = end_of_stream;
            case (phase_reg)
                PH_BYTE:
                begin
                    if (flag_reg[0])
                        lit_next = scr;
                    else
                    begin
                        low_next   = scr;
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    src_next    = {scr[7:4], low_reg};
                    len_m1_next = {1'b0, scr[3:0]} + MATCH_BIAS;
                    idx_next    = 5'd0;
                end
                default:
                begin
                    flag_next  = scr;
                    left_next  = FLAG_COUNT;
                    phase_next = PH_BYTE;
                end
            endcase
        end

        if (cmd.rd_issue)
            rd_valid_next = rd_hit;

        if (emit)
        begin
            wp_next        = wp_reg + 1'b1;
            out_valid_next = 1'b1;
            out_byte_next  = emit_data;
            run_last_next  = cmd.lit_emit || stat.match_end;
            if (fill_reg != WIN_DEPTH)
                fill_next = fill_reg + 1'b1;
        end

        if (cmd.match_emit)
            idx_next = idx_reg + 5'd1;

        if (finish)
        begin
            flag_next  = {1'b0, flag_reg[7:1]};
            left_next  = left_dec;
            phase_next = (left_dec == 4'd0) ? PH_FLAG : PH_BYTE;
        end

        // Drop the stream context after the last item: at its accept if it gives no output, else after its output.
        if (clear)
        begin
            pos_next       = 8'd0;
            phase_next     = PH_FLAG;
            flag_next      = 8'd0;
            left_next      = 4'd0;
            low_next       = 8'd0;
            wp_next        = WIN_START;
            fill_next      = '0;
            pend_last_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= KEY_RESET;
            pos_reg       <= 8'd0;
            phase_reg     <= PH_FLAG;
            flag_reg      <= 8'd0;
            left_reg      <= 4'd0;
            low_reg       <= 8'd0;
            wp_reg        <= WIN_START;
            fill_reg      <= '0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                key_reg <= cfg_wr_data;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            flag_reg      <= flag_next;
            left_reg      <= left_next;
            low_reg       <= low_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg      <= lit_next;
        src_reg      <= src_next;
        len_m1_reg   <= len_m1_next;
        idx_reg      <= idx_next;
        rd_valid_reg <= rd_valid_next;
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            win_mem[wp_reg] <= emit_data;
        if (cmd.rd_issue)
            rdata_reg <= win_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

endmodule

/* design/lzss_descramble_decompressor.sv */
// ----------------------------------------------------------------------------
// lzss_descramble_decompressor: XOR-descrambled LZSS decoder, 4 KiB window
// Path: flag/match-low items are absorbed at accept; a literal goes via lit_reg to the output register.
// Match copy: a match item copies len bytes (len 3..18), alternating a window
// RAM read and an output write per copied byte; output stalls slow it.
// Reset: no clearing pass; window valid tracked by a fill count, ready at once.
// ----------------------------------------------------------------------------
`include "lzss_descramble_decompressor_defines.svh"

module lzss_descramble_decompressor (
    input  logic       clk,
    input  logic       rst_n,
    // configuration: descramble key
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    // compressed input
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_stream,
    // decompressed output
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last
);
    import lzssd_pkg::*;

    // The controller takes an item only in its idle state. Flag bytes and the
    // low byte of a match are absorbed in that cycle; a literal moves to the
    // output register once it is free; a match alternates window read and emit per byte.
    // The single output register lets the next item in while a result waits.
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    lzssd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath holds key, decode phase, flag bits, byte position, write
    // pointer, fill count and the 4096-entry history RAM. A window entry
    // outside the fill count reads as zero, so at end of stream the window
    // needs only its pointer and count reset.
    lzssd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .cmd           (cmd),
        .stat          (stat)
    );

    // Never load the output register over an untaken item.
    `LZSSD_ASSERT_NOW(a_emit_free, clk, rst_n, cmd.lit_emit || cmd.match_emit, stat.out_free, "output register overwritten")
    // At most one controller command per cycle.
    `LZSSD_ASSERT_NOW(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0({cmd.accept, cmd.lit_emit, cmd.rd_issue, cmd.match_emit}), "conflicting commands")
    // A match item starts its copy with a window read in the next cycle.
    `LZSSD_ASSERT_NEXT(a_match_read, clk, rst_n, cmd.accept && stat.kind == KIND_MATCH, cmd.rd_issue, "match copy did not start")
    // Every window read is followed by an emit attempt with the item held.
    `LZSSD_ASSERT_NEXT(a_read_hold, clk, rst_n, cmd.rd_issue, in_stall && !cmd.rd_issue, "read not followed by emit")

endmodule
